[rtl/core/efp_pkg.sv]
`timescale 1ns / 1ps

package efp_pkg;

    // Framing bytes
    localparam logic [7:0] START_BYTE = 8'hBE;
    localparam logic [7:0] END_BYTE   = 8'hEF;
    localparam logic [7:0] ESC_BYTE   = 8'hAB;

    // Command codes
    localparam logic [7:0] CODE_BCAST = 8'h01;
    localparam logic [7:0] CODE_RSSI  = 8'h03;

    // Record kinds
    localparam logic KIND_BCAST = 1'b0;
    localparam logic KIND_RSSI  = 1'b1;

    // Parser position within a frame
    typedef enum logic [8:0] {
        MODE_HUNT    = 9'b000000001,
        MODE_CMD     = 9'b000000010,
        MODE_B_DEST  = 9'b000000100,
        MODE_B_UID   = 9'b000001000,
        MODE_B_CNT   = 9'b000010000,
        MODE_B_DELAY = 9'b000100000,
        MODE_R_DEST  = 9'b001000000,
        MODE_R_UID   = 9'b010000000,
        MODE_END     = 9'b100000000
    } parse_mode_t;

    // Input item
    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    // Result item
    typedef struct packed {
        logic       command_kind;
        logic [7:0] dest_id;
        logic [7:0] beacon_uid;
        logic [7:0] burst_count;
        logic [7:0] burst_delay_ms;
    } cmd_item_t;

    // Parser result handed to the output stage
    typedef struct packed {
        logic      emit;
        cmd_item_t item;
    } parse_result_t;

endpackage

[rtl/core/efp_stream_if.sv]
`timescale 1ns / 1ps

interface efp_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/efp_parser.sv]
`timescale 1ns / 1ps

module efp_parser
    import efp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    output parse_result_t result
);

    parse_mode_t mode_reg, mode_next;
    logic        esc_armed_reg, esc_armed_next;
    logic [7:0]  code_reg, code_next;
    logic [7:0]  bcast_dest_reg, bcast_dest_next;
    logic [7:0]  rssi_dest_reg, rssi_dest_next;
    logic [7:0]  uid_reg, uid_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  delay_reg, delay_next;
    logic        field_pos;
    logic        take_lit;

    // A byte in a field position counts unless it opens an escape
    assign take_lit = !(esc_armed_reg && (rx_byte == ESC_BYTE));

    // Advance the frame state for the current byte
    always_comb
    begin
        mode_next       = mode_reg;
        esc_armed_next  = esc_armed_reg;
        code_next       = code_reg;
        bcast_dest_next = bcast_dest_reg;
        rssi_dest_next  = rssi_dest_reg;
        uid_next        = uid_reg;
        count_next      = count_reg;
        delay_next      = delay_reg;
        field_pos       = 1'b0;
        result.emit     = 1'b0;

        unique case (mode_reg)
            MODE_HUNT:
            begin
                mode_next      = (rx_byte == START_BYTE) ? MODE_CMD : MODE_HUNT;
                esc_armed_next = 1'b1;
            end
            MODE_CMD:
            begin
                field_pos = 1'b1;
                if (take_lit)
                begin
                    code_next = rx_byte;
                    if (rx_byte == CODE_BCAST)
                        mode_next = MODE_B_DEST;
                    else if (rx_byte == CODE_RSSI)
                        mode_next = MODE_R_DEST;
                    else
                        mode_next = MODE_HUNT;
                end
            end
            MODE_B_DEST:
            begin
                field_pos = 1'b1;
                if (take_lit)
                begin
                    bcast_dest_next = rx_byte;
                    mode_next       = MODE_B_UID;
                end
            end
            MODE_B_UID:
            begin
                field_pos = 1'b1;
                if (take_lit)
                begin
                    uid_next  = rx_byte;
                    mode_next = MODE_B_CNT;
                end
            end
            MODE_B_CNT:
            begin
                field_pos = 1'b1;
                if (take_lit)
                begin
                    count_next = rx_byte;
                    mode_next  = MODE_B_DELAY;
                end
            end
            MODE_B_DELAY:
            begin
                field_pos = 1'b1;
                if (take_lit)
                begin
                    delay_next = rx_byte;
                    mode_next  = MODE_END;
                end
            end
            MODE_R_DEST:
            begin
                field_pos = 1'b1;
                if (take_lit)
                begin
                    rssi_dest_next = rx_byte;
                    mode_next      = MODE_R_UID;
                end
            end
            MODE_R_UID:
            begin
                field_pos = 1'b1;
                if (take_lit)
                begin
                    uid_next  = rx_byte;
                    mode_next = MODE_END;
                end
            end
            MODE_END:
            begin
                // End byte is never escaped; anything else drops the frame
                mode_next   = MODE_HUNT;
                result.emit = (rx_byte == END_BYTE) &&
                              ((code_reg == CODE_BCAST) || (code_reg == CODE_RSSI));
            end
            default:
            begin
                mode_next = MODE_HUNT;
            end
        endcase

        // Disarm on an escape byte, rearm after the literal byte
        if (field_pos)
            esc_armed_next = !take_lit ? 1'b0 : 1'b1;

        // Build the record from the held fields
        result.item.command_kind   = (code_reg == CODE_RSSI) ? KIND_RSSI : KIND_BCAST;
        result.item.dest_id        = (code_reg == CODE_RSSI) ? rssi_dest_reg : bcast_dest_reg;
        result.item.beacon_uid     = uid_reg;
        result.item.burst_count    = count_reg;
        result.item.burst_delay_ms = delay_reg;
    end

    // Control state and held fields that have a defined reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HUNT;
            esc_armed_reg <= 1'b1;
            uid_reg       <= '0;
            count_reg     <= '0;
            delay_reg     <= '0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            esc_armed_reg <= esc_armed_next;
            uid_reg       <= uid_next;
            count_reg     <= count_next;
            delay_reg     <= delay_next;
        end
    end

    // Fields written before any record reads them
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            code_reg       <= code_next;
            bcast_dest_reg <= bcast_dest_next;
            rssi_dest_reg  <= rssi_dest_next;
        end
    end

endmodule

[rtl/core/efp_out_stage.sv]
`timescale 1ns / 1ps

module efp_out_stage
    import efp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  parse_result_t result,
    input  logic          out_ready,
    output logic          out_valid,
    output cmd_item_t     out_item,
    output logic          can_load
);

    logic      valid_reg, valid_next;
    cmd_item_t item_reg;

    // Room for a new record when empty or draining this cycle
    assign can_load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load && result.emit)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the record payload
    always_ff @(posedge clk)
    begin
        if (load && result.emit)
            item_reg <= result.item;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[rtl/core/escaped_command_frame_parser.sv]
`timescale 1ns / 1ps

// Byte-stuffed command frame parser. Takes one serial byte per cycle on rx and
// issues one command record on cmd for each complete broadcast or rssi request
// frame; the record is registered and appears in the cycle after its end byte
// is taken. A new byte is taken every cycle while rx is ready, as the frame
// state register updates on each taken byte; rx stalls only while a finished
// record sits in the output register and cmd is not ready. No clearing pass after reset.

module escaped_command_frame_parser
    import efp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    efp_stream_if.sink   rx,
    efp_stream_if.source cmd
);

    parse_result_t result;
    logic          accept;
    logic          can_load;

    assign rx.ready = can_load;
    assign accept   = rx.valid && can_load;

    efp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx.data.rx_byte),
        .result  (result)
    );

    efp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .result    (result),
        .out_ready (cmd.ready),
        .out_valid (cmd.valid),
        .out_item  (cmd.data),
        .can_load  (can_load)
    );

    // Hold input while a record waits
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && !cmd.ready) |-> !rx.ready)
        else $error("rx taken while record stalled");

    // Record only follows an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.valid) |-> $past(rx.valid && rx.ready))
        else $error("record without accepted byte");

    // Emitted record lands in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && result.emit) |=> (cmd.valid && (cmd.data == $past(result.item))))
        else $error("record lost or corrupted");

    // Only an end byte closes a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        result.emit |-> (rx.data.rx_byte == END_BYTE))
        else $error("record emitted on non-end byte");

endmodule
